[rtl/bsfe_pkg.sv]
// ----------------------------------------------------------------------------
// bsfe_pkg: shared definitions of the bitmap shape fill engine
// Field widths, command and register codes, and the row edge descriptor.
// ----------------------------------------------------------------------------
package bsfe_pkg;

	localparam int ROW_BITS_W = 64;   // width of one emitted row
	localparam int ROW_IDX_W  = 6;    // row number field
	localparam int COORD_W    = 6;    // column or row coordinate
	localparam int DIM_W      = 7;    // size and canvas dimensions
	localparam int FUNC_W     = 2;
	localparam int CORNER_W   = 2;
	localparam int CFG_IDX_W  = 8;

	localparam int MAX_COLUMNS_DEF = 64;
	localparam int MAX_ROWS_DEF    = 64;

	localparam int IN_DATA_W  = 40;   // 33 field bits padded to bytes
	localparam int OUT_DATA_W = 72;   // 70 field bits padded to bytes

	typedef logic [FUNC_W-1:0]    func_t;
	typedef logic [CORNER_W-1:0]  corner_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam func_t FUNC_SQUARE   = 2'd0;
	localparam func_t FUNC_TRIANGLE = 2'd1;
	localparam func_t FUNC_LINE     = 2'd2;

	localparam corner_t CORNER_RIGHT_UP   = 2'd0;
	localparam corner_t CORNER_RIGHT_DOWN = 2'd1;
	localparam corner_t CORNER_LEFT_UP    = 2'd2;
	localparam corner_t CORNER_LEFT_DOWN  = 2'd3;

	localparam cfg_idx_t CFG_CANVAS_WIDTH  = 8'd0;
	localparam cfg_idx_t CFG_CANVAS_HEIGHT = 8'd1;

	// one edge of the filled span: column at the first active row, and
	// whether it moves by one column per row, and in which direction
	typedef struct packed {
		logic [COORD_W-1:0] base;
		logic               step;
		logic               neg;
	} edge_t;

endpackage

[rtl/bitmap_shape_fill_engine_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_shape_fill_engine_unit: one-bit canvas with shape drawing commands
// Draws squares, right triangles and straight lines, then streams the canvas.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one drawing command per transaction (func in tuser, the
//   geometry in tdata). cfg sets canvas_width (index 0) and canvas_height
//   (index 1); write it only while the block is idle. cfg_ready is always high.
//   m_axis returns, for a drawn shape, every row of the canvas in use from
//   row 0 up, tlast on the final row; for a rejected shape it returns one
//   transaction with tuser (status) set, tdata zero and tlast set.
// Timing
//   A command has its bounds checked in ST_CHECK, then takes one canvas read
//   before the first row; rows then leave at one per cycle while m_axis does
//   not stall. The rate is set by the single read and write port of the canvas
//   RAM, swept once per command: each row is read, merged with the shape span
//   and written back. s_axis_tready is high only while no command is in
//   progress.
// Reset and stalls
//   Reset clears the canvas at once through per-row written flags (no
//   clearing pass) and restores both dimensions to their maxima. A stall on
//   m_axis freezes the sweep; the pending row read waits in the RAM register.
// ----------------------------------------------------------------------------
module bitmap_shape_fill_engine_unit #(
	parameter int MAX_COLUMNS = bsfe_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = bsfe_pkg::MAX_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// size[6:0], x_pos[12:7], y_pos[18:13], corner[20:19],
	// x_end[26:21], y_end[32:27], zero padding above
	input  logic [bsfe_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// func[1:0]
	input  logic [bsfe_pkg::FUNC_W-1:0]          s_axis_tuser,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bsfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsfe_pkg::DIM_W-1:0]           cfg_data,
	// row stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// row_bits[63:0], row_index[69:64], zero padding above
	output logic [bsfe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status[0]
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);

	import bsfe_pkg::*;

	localparam int RAM_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [ROW_BITS_W-1:0] ALL_ONES = '1;
	localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_COLUMNS);
	localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_ROWS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FAIL,
		ST_SWEEP
	} state_t;

	state_t state_q;

	// configuration
	logic [DIM_W-1:0] width_q, height_q;

	// latched command
	func_t              func_q;
	logic [DIM_W-1:0]   size_q;
	logic [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
	corner_t            corner_q;

	// shape description for the sweep
	logic [COORD_W-1:0] row_lo_q, row_hi_q;
	edge_t              lo_edge_q, hi_edge_q;

	// sweep control
	logic [ROW_IDX_W-1:0] cur_row_q;
	logic                 rd_vld_q;
	logic [MAX_ROWS-1:0]  row_written_q;

	// output register
	logic                  out_valid_q;
	logic [ROW_BITS_W-1:0] out_bits_q;
	logic [ROW_IDX_W-1:0]  out_idx_q;
	logic                  out_status_q, out_last_q;

	// ------------------------------------------------------------------
	// Bounds check and span description, evaluated on the latched command
	// ------------------------------------------------------------------
	logic               ok_d;
	logic [COORD_W-1:0] row_lo_d, row_hi_d;
	edge_t              lo_edge_d, hi_edge_d;

	always_comb begin
		logic [DIM_W:0]     sx, xs, ys, x1, y1;
		logic [DIM_W:0]     ww, hh;
		logic [COORD_W-1:0] adx, ady, xmin, xmax, ymin, ymax, x_top;
		logic               up, right, x_top_left;
		sx  = {1'b0, size_q};
		ww  = {1'b0, width_q};
		hh  = {1'b0, height_q};
		xs  = {2'b00, x_q} + sx;
		ys  = {2'b00, y_q} + sx;
		x1  = {2'b00, x_q} + (DIM_W+1)'(1);
		y1  = {2'b00, y_q} + (DIM_W+1)'(1);
		up    = (corner_q == CORNER_RIGHT_UP) || (corner_q == CORNER_LEFT_UP);
		right = (corner_q == CORNER_RIGHT_UP) || (corner_q == CORNER_RIGHT_DOWN);
		xmin = (x_q < xe_q) ? x_q : xe_q;
		xmax = (x_q < xe_q) ? xe_q : x_q;
		ymin = (y_q < ye_q) ? y_q : ye_q;
		ymax = (y_q < ye_q) ? ye_q : y_q;
		adx  = xmax - xmin;
		ady  = ymax - ymin;
		// column of the endpoint nearest row 0, and whether the line runs
		// right from it
		x_top      = (y_q < ye_q) ? x_q : xe_q;
		x_top_left = (y_q < ye_q) ? (xe_q > x_q) : (x_q > xe_q);

		ok_d      = 1'b0;
		row_lo_d  = y_q;
		row_hi_d  = y_q;
		lo_edge_d = '{base: x_q, step: 1'b0, neg: 1'b0};
		hi_edge_d = '{base: x_q, step: 1'b0, neg: 1'b0};

		unique case (func_q)
			FUNC_SQUARE: begin
				ok_d     = (size_q != '0) && (xs <= ww) && (ys <= hh);
				row_hi_d = COORD_W'(ys - (DIM_W+1)'(1));
				hi_edge_d.base = COORD_W'(xs - (DIM_W+1)'(1));
			end
			FUNC_TRIANGLE: begin
				ok_d = (size_q != '0) && ({2'b00, x_q} < ww) && ({2'b00, y_q} < hh)
					&& (up ? (y1 >= sx) : (ys <= hh))
					&& (right ? (xs <= ww) : (x1 >= sx));
				if (up) begin
					row_lo_d = COORD_W'(y1 - sx);
				end else begin
					row_hi_d = COORD_W'(ys - (DIM_W+1)'(1));
				end
				// the sloped edge shrinks away from the anchor row
				if (right) begin
					hi_edge_d.step = 1'b1;
					hi_edge_d.neg  = !up;
					hi_edge_d.base = up ? x_q : COORD_W'(xs - (DIM_W+1)'(1));
				end else begin
					lo_edge_d.step = 1'b1;
					lo_edge_d.neg  = up;
					lo_edge_d.base = up ? x_q : COORD_W'(x1 - sx);
				end
			end
			FUNC_LINE: begin
				ok_d = ({2'b00, x_q} < ww) && ({2'b00, xe_q} < ww)
					&& ({2'b00, y_q} < hh) && ({2'b00, ye_q} < hh)
					&& ((ady == '0) || (adx == '0) || (adx == ady));
				row_lo_d = ymin;
				row_hi_d = ymax;
				if (ady == '0) begin
					lo_edge_d.base = xmin;
					hi_edge_d.base = xmax;
				end else if (adx != '0) begin
					lo_edge_d = '{base: x_top, step: 1'b1, neg: !x_top_left};
					hi_edge_d = lo_edge_d;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Span of the current row and the merged row
	// ------------------------------------------------------------------
	logic [COORD_W-1:0]    row_off, c0, c1;
	logic                  row_active, is_last_row, out_free, consume, rd_issue, fail_load;
	logic [ROW_BITS_W-1:0] span_mask, old_row, new_row, width_mask;
	logic [MAX_COLUMNS-1:0] ram_rd_data;
	logic [ROW_IDX_W-1:0]  rd_row;

	function automatic logic [COORD_W-1:0] edge_col(edge_t e, logic [COORD_W-1:0] off);
		logic [COORD_W-1:0] col;
		col = e.base;
		if (e.step) begin
			col = e.neg ? (e.base - off) : (e.base + off);
		end
		return col;
	endfunction

	assign row_off    = COORD_W'(cur_row_q) - row_lo_q;
	assign c0         = edge_col(lo_edge_q, row_off);
	assign c1         = edge_col(hi_edge_q, row_off);
	assign row_active = (COORD_W'(cur_row_q) >= row_lo_q) && (COORD_W'(cur_row_q) <= row_hi_q);
	assign span_mask  = row_active ? ((ALL_ONES << c0) & (ALL_ONES >> (~c1))) : '0;

	// a row never written since reset reads as empty
	assign old_row    = row_written_q[cur_row_q[RAM_AW-1:0]] ? ROW_BITS_W'(ram_rd_data) : '0;
	assign new_row    = old_row | span_mask;
	assign width_mask = ALL_ONES >> (DIM_W'(ROW_BITS_W) - width_q);

	assign is_last_row = ({1'b0, cur_row_q} == (height_q - DIM_W'(1)));
	assign out_free    = !out_valid_q || m_axis_tready;
	assign consume     = (state_q == ST_SWEEP) && rd_vld_q && out_free;
	assign fail_load   = (state_q == ST_FAIL) && out_free;
	assign rd_issue    = (state_q == ST_SWEEP) && (!rd_vld_q || (consume && !is_last_row));
	assign rd_row      = rd_vld_q ? (cur_row_q + ROW_IDX_W'(1)) : cur_row_q;

	bsfe_ram #(
		.WIDTH (MAX_COLUMNS),
		.DEPTH (MAX_ROWS),
		.ADDR_W(RAM_AW)
	) u_canvas (
		.clk    (clk),
		.wr_en  (consume),
		.wr_addr(cur_row_q[RAM_AW-1:0]),
		.wr_data(new_row[MAX_COLUMNS-1:0]),
		.rd_en  (rd_issue),
		.rd_addr(rd_row[RAM_AW-1:0]),
		.rd_data(ram_rd_data)
	);

	// ------------------------------------------------------------------
	// Configuration: clamp to 1..maximum on write
	// ------------------------------------------------------------------
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_W;
			height_q <= MAX_H;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CANVAS_WIDTH) begin
				width_q <= clamp_dim(cfg_data, MAX_W);
			end else if (cfg_index == CFG_CANVAS_HEIGHT) begin
				height_q <= clamp_dim(cfg_data, MAX_H);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and output register
	// ------------------------------------------------------------------
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_vld_q      <= 1'b0;
			cur_row_q     <= '0;
			row_written_q <= '0;
			out_valid_q   <= 1'b0;
			func_q        <= FUNC_SQUARE;
			size_q        <= '0;
			x_q           <= '0;
			y_q           <= '0;
			corner_q      <= CORNER_RIGHT_UP;
			xe_q          <= '0;
			ye_q          <= '0;
			row_lo_q      <= '0;
			row_hi_q      <= '0;
			lo_edge_q     <= '0;
			hi_edge_q     <= '0;
			out_bits_q    <= '0;
			out_idx_q     <= '0;
			out_status_q  <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// load a fresh result, or drop the held one once taken
			if (consume || fail_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						func_q   <= s_axis_tuser;
						size_q   <= s_axis_tdata[6:0];
						x_q      <= s_axis_tdata[12:7];
						y_q      <= s_axis_tdata[18:13];
						corner_q <= s_axis_tdata[20:19];
						xe_q     <= s_axis_tdata[26:21];
						ye_q     <= s_axis_tdata[32:27];
						state_q  <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					row_lo_q  <= row_lo_d;
					row_hi_q  <= row_hi_d;
					lo_edge_q <= lo_edge_d;
					hi_edge_q <= hi_edge_d;
					cur_row_q <= '0;
					rd_vld_q  <= 1'b0;
					state_q   <= ok_d ? ST_SWEEP : ST_FAIL;
				end
				ST_FAIL: begin
					if (fail_load) begin
						out_bits_q   <= '0;
						out_idx_q    <= '0;
						out_status_q <= 1'b1;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (rd_issue) begin
						rd_vld_q <= 1'b1;
					end
					if (consume) begin
						row_written_q[cur_row_q[RAM_AW-1:0]] <= 1'b1;
						out_bits_q   <= new_row & width_mask;
						out_idx_q    <= cur_row_q;
						out_status_q <= 1'b0;
						out_last_q   <= is_last_row;
						if (is_last_row) begin
							rd_vld_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							cur_row_q <= cur_row_q + ROW_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-ROW_BITS_W-ROW_IDX_W){1'b0}}, out_idx_q, out_bits_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a rejected command yields one empty, final transaction
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("rejected command result is not an empty final row");

	// a row before the last never carries the row number of the last row
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && !m_axis_tlast
		|-> ({1'b0, m_axis_tdata[69:64]} < (height_q - DIM_W'(1))))
		else $error("intermediate row index at or beyond the last row");

	// a canvas read is outstanding only during a sweep
	a_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == ST_SWEEP))
		else $error("canvas read pending outside the sweep");

	// the final row of a sweep returns the block to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		consume && is_last_row |=> (state_q == ST_IDLE) && m_axis_tlast && m_axis_tvalid)
		else $error("sweep did not end on its final row");

endmodule

[rtl/bsfe_ram.sv]
// ----------------------------------------------------------------------------
// bsfe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module bsfe_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bitmap shape fill engine
// Sends drawing commands over the command stream while a shadow canvas
// predicts every row transaction. Each returned row is compared field by
// field. Canvas dimensions are reprogrammed between phases. Both stream
// sides idle at random, and one phase holds the row stream off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
	import bsfe_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	// settle time once the last due row is in
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 90;
	// the one command code that the block does not define
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct packed {
		func_t                func;
		logic [DIM_W-1:0]     size;
		logic [COORD_W-1:0]   x_pos;
		logic [COORD_W-1:0]   y_pos;
		corner_t              corner;
		logic [COORD_W-1:0]   x_end;
		logic [COORD_W-1:0]   y_end;
	} shape_cmd_t;

	typedef struct packed {
		logic [ROW_BITS_W-1:0] row_bits;
		logic [ROW_IDX_W-1:0]  row_index;
		logic                  status;
		logic                  last;
	} canvas_row_t;

	// block ports; every input starts at a known value
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [FUNC_W-1:0]     s_axis_tuser  = '0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [DIM_W-1:0]      cfg_data      = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// shadow of the block: canvas contents and dimensions in use
	logic [ROW_BITS_W-1:0] shadow_canvas [MAX_ROWS_DEF];
	int                    canvas_w;
	int                    canvas_h;
	canvas_row_t           rows_due [$];

	int mismatches     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;   // long hold-off asked for by a test
	int hold_left      = 0;   // owned by the row stream receiver

	bitmap_shape_fill_engine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Row stream receiver: a requested hold-off overrides random stalls
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Row checker: every accepted row transaction against the oldest one due
	always @(posedge clk) begin
		canvas_row_t seen;
		canvas_row_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.row_bits  = m_axis_tdata[ROW_BITS_W-1:0];
			seen.row_index = m_axis_tdata[ROW_BITS_W +: ROW_IDX_W];
			seen.status    = m_axis_tuser;
			seen.last      = m_axis_tlast;
			if (rows_due.size() == 0) begin
				$display("%0t: row transaction with nothing due, got %h", $time, seen);
				mismatches++;
			end else begin
				due = rows_due.pop_front();
				if (seen.row_bits !== due.row_bits) begin
					$display("%0t: row_bits expected %h got %h",
						$time, due.row_bits, seen.row_bits);
					mismatches++;
				end
				if (seen.row_index !== due.row_index) begin
					$display("%0t: row_index expected %0d got %0d",
						$time, due.row_index, seen.row_index);
					mismatches++;
				end
				if (seen.status !== due.status) begin
					$display("%0t: status expected %b got %b",
						$time, due.status, seen.status);
					mismatches++;
				end
				if (seen.last !== due.last) begin
					$display("%0t: last expected %b got %b",
						$time, due.last, seen.last);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- shadow

	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
		if (v == 0)
			return 1;
		if (int'(v) > top)
			return top;
		return int'(v);
	endfunction

	function automatic void fill_span(input int r, input int c0, input int c1);
		for (int c = c0; c <= c1; c++)
			shadow_canvas[r][c] = 1'b1;
	endfunction

	function automatic bit place_square(input int s, input int x, input int y);
		if (s < 1 || x + s > canvas_w || y + s > canvas_h)
			return 1'b0;
		for (int r = y; r < y + s; r++)
			fill_span(r, x, x + s - 1);
		return 1'b1;
	endfunction

	// right angle at (x,y); each row away from it is one cell shorter
	function automatic bit place_triangle(input int s, input int x, input int y,
			input corner_t k);
		bit up;
		bit right;
		int r;
		int len;
		up    = (k == CORNER_RIGHT_UP || k == CORNER_LEFT_UP);
		right = (k == CORNER_RIGHT_UP || k == CORNER_RIGHT_DOWN);
		if (s < 1 || x >= canvas_w || y >= canvas_h)
			return 1'b0;
		if (up ? (y - s + 1 < 0) : (y + s > canvas_h))
			return 1'b0;
		if (right ? (x + s > canvas_w) : (x - s + 1 < 0))
			return 1'b0;
		for (int d = 0; d < s; d++) begin
			r   = up ? y - d : y + d;
			len = s - d;
			if (right)
				fill_span(r, x, x + len - 1);
			else
				fill_span(r, x - len + 1, x);
		end
		return 1'b1;
	endfunction

	// walk from start to end one cell at a time; only 0, 90 and 45 degrees
	function automatic bit place_line(input int x1, input int y1, input int x2,
			input int y2);
		int dx;
		int dy;
		int sx;
		int sy;
		int steps;
		if (x1 >= canvas_w || x2 >= canvas_w || y1 >= canvas_h || y2 >= canvas_h)
			return 1'b0;
		dx = x2 - x1;
		dy = y2 - y1;
		if (dx != 0 && dy != 0 && dx != dy && dx != -dy)
			return 1'b0;
		sx    = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
		sy    = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
		steps = (dx * sx > dy * sy) ? dx * sx : dy * sy;
		for (int k = 0; k <= steps; k++)
			fill_span(y1 + k * sy, x1 + k * sx, x1 + k * sx);
		return 1'b1;
	endfunction

	// Draw on the shadow canvas and queue the rows the command must return
	function automatic void predict_rows(input shape_cmd_t c);
		bit                    drawn;
		logic [ROW_BITS_W-1:0] keep;
		canvas_row_t           e;
		case (c.func)
			FUNC_SQUARE:   drawn = place_square(int'(c.size), int'(c.x_pos), int'(c.y_pos));
			FUNC_TRIANGLE: drawn = place_triangle(int'(c.size), int'(c.x_pos),
				int'(c.y_pos), c.corner);
			FUNC_LINE:     drawn = place_line(int'(c.x_pos), int'(c.y_pos),
				int'(c.x_end), int'(c.y_end));
			default:       drawn = 1'b0;
		endcase
		if (!drawn) begin
			e = '0;
			e.status = 1'b1;
			e.last   = 1'b1;
			rows_due.push_back(e);
		end else begin
			keep = {ROW_BITS_W{1'b1}} >> (ROW_BITS_W - canvas_w);
			for (int r = 0; r < canvas_h; r++) begin
				e.row_bits  = shadow_canvas[r] & keep;
				e.row_index = r[ROW_IDX_W-1:0];
				e.status    = 1'b0;
				e.last      = (r == canvas_h - 1);
				rows_due.push_back(e);
			end
		end
	endfunction

	// -------------------------------------------------------------- stimulus

	function automatic shape_cmd_t shape(input func_t f, input int s, input int x,
			input int y, input corner_t k, input int xe, input int ye);
		shape_cmd_t c;
		c.func   = f;
		c.size   = s[DIM_W-1:0];
		c.x_pos  = x[COORD_W-1:0];
		c.y_pos  = y[COORD_W-1:0];
		c.corner = k;
		c.x_end  = xe[COORD_W-1:0];
		c.y_end  = ye[COORD_W-1:0];
		return c;
	endfunction

	// Mostly shapes that fit the canvas in use, the rest raw noise
	function automatic shape_cmd_t random_cmd();
		shape_cmd_t c;
		int         lim;
		int         s;
		int         len;
		int         xa;
		int         ya;
		corner_t    k;
		if ($urandom_range(99) < 20) begin
			c.func   = func_t'($urandom);
			c.size   = DIM_W'($urandom);
			c.x_pos  = COORD_W'($urandom);
			c.y_pos  = COORD_W'($urandom);
			c.corner = corner_t'($urandom);
			c.x_end  = COORD_W'($urandom);
			c.y_end  = COORD_W'($urandom);
			return c;
		end
		lim = (canvas_w < canvas_h) ? canvas_w : canvas_h;
		// keep shapes small so the canvas fills slowly; now and then go large
		s = $urandom_range(1, (lim < 6) ? lim : 6);
		if ($urandom_range(19) == 0)
			s = $urandom_range(1, lim);
		case ($urandom_range(2))
			0: begin
				c = shape(FUNC_SQUARE, s, $urandom_range(0, canvas_w - s),
					$urandom_range(0, canvas_h - s), corner_t'($urandom), $urandom,
					$urandom);
			end
			1: begin
				k  = corner_t'($urandom);
				xa = (k == CORNER_RIGHT_UP || k == CORNER_RIGHT_DOWN) ?
					$urandom_range(0, canvas_w - s) : $urandom_range(s - 1, canvas_w - 1);
				ya = (k == CORNER_RIGHT_UP || k == CORNER_LEFT_UP) ?
					$urandom_range(s - 1, canvas_h - 1) : $urandom_range(0, canvas_h - s);
				c = shape(FUNC_TRIANGLE, s, xa, ya, k, $urandom, $urandom);
			end
			default: begin
				c = shape(FUNC_LINE, $urandom, 0, 0, corner_t'($urandom), 0, 0);
				case ($urandom_range(2))
					0: begin
						c.y_pos = COORD_W'($urandom_range(0, canvas_h - 1));
						c.y_end = c.y_pos;
						c.x_pos = COORD_W'($urandom_range(0, canvas_w - 1));
						c.x_end = COORD_W'($urandom_range(0, canvas_w - 1));
					end
					1: begin
						c.x_pos = COORD_W'($urandom_range(0, canvas_w - 1));
						c.x_end = c.x_pos;
						c.y_pos = COORD_W'($urandom_range(0, canvas_h - 1));
						c.y_end = COORD_W'($urandom_range(0, canvas_h - 1));
					end
					default: begin
						len = $urandom_range(0, lim - 1);
						xa  = $urandom_range(0, canvas_w - 1 - len);
						ya  = $urandom_range(0, canvas_h - 1 - len);
						c.x_pos = COORD_W'(xa);
						c.x_end = COORD_W'(xa + len);
						// rising or falling diagonal
						if ($urandom_range(1)) begin
							c.y_pos = COORD_W'(ya);
							c.y_end = COORD_W'(ya + len);
						end else begin
							c.y_pos = COORD_W'(ya + len);
							c.y_end = COORD_W'(ya);
						end
					end
				endcase
				// either endpoint may come first
				if ($urandom_range(1))
					c = shape(FUNC_LINE, int'(c.size), int'(c.x_end), int'(c.y_end),
						c.corner, int'(c.x_pos), int'(c.y_pos));
			end
		endcase
		return c;
	endfunction

	// Offer one command and hold it until the block takes it; tvalid stays
	// high into the next command unless an idle gap is drawn
	task automatic send_cmd(input shape_cmd_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-33){1'b0}}, c.y_end, c.x_end, c.corner,
			c.y_pos, c.x_pos, c.size};
		s_axis_tuser  <= c.func;
		do @(posedge clk); while (!s_axis_tready);
		predict_rows(c);
	endtask

	// Stop offering and wait for every due row, then let the block settle
	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reprogram both dimensions while idle; cfg_valid stays high across both
	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		pause_until_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_CANVAS_HEIGHT;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		canvas_w = clamp_dim(w, MAX_COLUMNS_DEF);
		canvas_h = clamp_dim(h, MAX_ROWS_DEF);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// ------------------------------------------------------------------ tests

	// Extremes, every command and corner, and rejection cases for each command
	task automatic test_directed();
		set_idling(18, 18);
		send_cmd(shape(FUNC_SQUARE, 1, 0, 0, CORNER_RIGHT_UP, 0, 0));
		send_cmd(shape(FUNC_SQUARE, 0, 5, 5, CORNER_RIGHT_UP, 0, 0));      // zero size
		send_cmd(shape(FUNC_SQUARE, 3, 61, 61, CORNER_RIGHT_UP, 0, 0));    // flush to far corner
		send_cmd(shape(FUNC_SQUARE, 4, 61, 0, CORNER_RIGHT_UP, 0, 0));     // one column over
		send_cmd(shape(FUNC_SQUARE, 127, 0, 0, CORNER_LEFT_DOWN, 63, 63));
		send_cmd(shape(FUNC_TRIANGLE, 5, 10, 20, CORNER_RIGHT_UP, 0, 0));
		send_cmd(shape(FUNC_TRIANGLE, 6, 40, 5, CORNER_RIGHT_DOWN, 0, 0));
		send_cmd(shape(FUNC_TRIANGLE, 4, 30, 40, CORNER_LEFT_UP, 0, 0));
		send_cmd(shape(FUNC_TRIANGLE, 8, 50, 50, CORNER_LEFT_DOWN, 0, 0));
		send_cmd(shape(FUNC_TRIANGLE, 0, 20, 20, CORNER_RIGHT_DOWN, 0, 0)); // zero size
		send_cmd(shape(FUNC_TRIANGLE, 4, 5, 2, CORNER_RIGHT_UP, 0, 0));    // past row 0
		send_cmd(shape(FUNC_TRIANGLE, 4, 2, 10, CORNER_LEFT_UP, 0, 0));    // past column 0
		send_cmd(shape(FUNC_TRIANGLE, 3, 10, 62, CORNER_RIGHT_DOWN, 0, 0)); // past last row
		send_cmd(shape(FUNC_TRIANGLE, 1, 63, 63, CORNER_RIGHT_UP, 0, 0));
		send_cmd(shape(FUNC_LINE, 0, 3, 30, CORNER_RIGHT_UP, 60, 30));     // horizontal
		send_cmd(shape(FUNC_LINE, 0, 60, 31, CORNER_RIGHT_UP, 3, 31));     // drawn backwards
		send_cmd(shape(FUNC_LINE, 0, 45, 0, CORNER_RIGHT_UP, 45, 63));     // vertical
		send_cmd(shape(FUNC_LINE, 0, 63, 63, CORNER_LEFT_DOWN, 63, 0));    // vertical, upwards
		send_cmd(shape(FUNC_LINE, 0, 0, 0, CORNER_RIGHT_UP, 63, 63));      // rising diagonal
		send_cmd(shape(FUNC_LINE, 0, 0, 63, CORNER_RIGHT_UP, 20, 43));     // falling diagonal
		send_cmd(shape(FUNC_LINE, 0, 40, 10, CORNER_RIGHT_UP, 30, 20));    // right to left
		send_cmd(shape(FUNC_LINE, 0, 7, 7, CORNER_RIGHT_UP, 7, 7));        // single cell
		send_cmd(shape(FUNC_LINE, 0, 0, 0, CORNER_RIGHT_UP, 5, 3));        // other slope
		send_cmd(shape(FUNC_UNUSED, 2, 1, 1, CORNER_RIGHT_UP, 1, 1));      // undefined command
	endtask

	// Dimension extremes, including values that clamp up to 1 and down to 64
	task automatic test_canvas_sizes();
		logic [DIM_W-1:0] dims [6][2];
		dims = '{'{7'd0, 7'd0}, '{7'd127, 7'd127}, '{7'd1, 7'd64}, '{7'd64, 7'd1},
			'{7'd0, 7'd100}, '{7'd13, 7'd37}};
		for (int p = 0; p < 6; p++) begin
			set_dims(dims[p][0], dims[p][1]);
			set_idling($urandom_range(0, 1) ? 18 : 0, $urandom_range(0, 1) ? 18 : 0);
			send_cmd(shape(FUNC_SQUARE, 1, 0, 0, CORNER_RIGHT_UP, 0, 0));
			send_cmd(shape(FUNC_LINE, 0, canvas_w - 1, 0, CORNER_RIGHT_UP,
				canvas_w - 1, canvas_h - 1));
			send_cmd(shape(FUNC_SQUARE, 1, canvas_w, 0, CORNER_RIGHT_UP, 0, 0)); // just off, or column 0 at width 64
			send_cmd(shape(FUNC_LINE, 0, 0, canvas_h, CORNER_RIGHT_UP, 0, 0));   // just off, or row 0 at height 64
			repeat (4) send_cmd(random_cmd());
		end
	endtask

	// Bulk random traffic through the four idling mixes; each phase breaks
	// halfway for the sender to wait out every outstanding row
	task automatic test_random_traffic();
		int mix [4][4];
		mix = '{'{64, 64, 0, 0}, '{37, 22, 83, 0}, '{64, 16, 0, 83}, '{20, 64, 18, 18}};
		for (int p = 0; p < 4; p++) begin
			set_dims(DIM_W'(mix[p][0]), DIM_W'(mix[p][1]));
			set_idling(mix[p][2], mix[p][3]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					pause_until_drained();
				send_cmd(random_cmd());
			end
		end
	endtask

	// Hold the row stream off while commands keep coming, so the block
	// backs up and refuses input until rows can leave again
	task automatic test_backpressure();
		set_dims(7'd64, 7'd64);
		set_idling(0, 0);
		hold_req = 400;
		repeat (8) send_cmd(random_cmd());
	endtask

	// Fill the whole canvas last, since drawn cells never clear
	task automatic test_full_canvas();
		set_dims(7'd64, 7'd64);
		set_idling(18, 18);
		send_cmd(shape(FUNC_TRIANGLE, 64, 63, 0, CORNER_LEFT_DOWN, 0, 0));
		send_cmd(shape(FUNC_SQUARE, 64, 0, 0, CORNER_RIGHT_UP, 0, 0));
		send_cmd(shape(FUNC_SQUARE, 64, 1, 0, CORNER_RIGHT_UP, 0, 0));
	endtask

	initial begin
		for (int r = 0; r < MAX_ROWS_DEF; r++)
			shadow_canvas[r] = '0;
		canvas_w = MAX_COLUMNS_DEF;
		canvas_h = MAX_ROWS_DEF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_canvas_sizes();
		test_random_traffic();
		test_backpressure();
		test_full_canvas();

		// final drain doubles as the tail wait for stray rows
		pause_until_drained();
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
